>>> src/htip_pkg.sv
// Shared definitions for the hex text parser: character codes, prefix modes,
// the character limit and the hex digit decoder. No dependencies.
`default_nettype none

package htip_pkg;

	// Longest kept string, prefix included.
	localparam logic [6:0] MAX_CHARS = 7'd66;

	localparam logic [7:0] CH_NUL       = 8'h00;
	localparam logic [7:0] CH_BACKSPACE = 8'h08;
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_ESC       = 8'h1B;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_X_LOWER   = 8'h78;
	localparam logic [7:0] CH_X_UPPER   = 8'h58;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	typedef enum logic [1:0] {
		PFX_NONE = 2'd0,
		PFX_ZERO = 2'd1,
		PFX_0X   = 2'd2,
		PFX_X    = 2'd3
	} prefix_mode_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} hex_digit_t;

	function automatic logic is_terminator(input logic [7:0] c);
		return (c == CH_NUL) || (c == CH_LF) || (c == CH_CR) || (c == CH_ESC);
	endfunction

	function automatic hex_digit_t hex_digit(input logic [7:0] c);
		hex_digit_t r;
		r.ok    = 1'b0;
		r.value = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r.ok    = 1'b1;
			r.value = c[3:0];
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			r.ok    = 1'b1;
			r.value = c[3:0] + 4'd9;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> src/hex_text_to_integer_parser_unit.sv
// An accepted transaction is held in the input register and then applied to the parser state;
// the edge that applies a terminator also loads its result into the result register.
// Throughput: one character per cycle, sustained; a terminator stalls only while the
// result register holds a result that has not been taken.
// Reset (arst_n low, asynchronous): parser state, input and output valids all clear.
// Top level of the hex text parser; depends on htip_pkg.
`default_nettype none

module hex_text_to_integer_parser_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         char_code,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [63:0]      parsed_value,
	output logic [6:0]              char_count,
	output logic                    status
);

	// Input register. Every accepted transaction lands here first; the character is
	// applied to the parser state when the input register advances.
	logic       valid_s1;
	logic [7:0] code_s1;

	// Parser state. The full character history is not kept: a backspace is undone from
	// the prefix mode, the kept length and the accumulator alone.
	logic [6:0]              kept_length_q;
	htip_pkg::prefix_mode_t  prefix_mode_q;
	logic [63:0]             acc_value_q;
	logic                    error_seen_q;

	// Result register, which separates the parser from the output handshake.
	logic        out_valid_q;
	logic [63:0] parsed_value_q;
	logic [6:0]  char_count_q;
	logic        status_q;

	logic                    term_s1;
	logic                    advance;
	htip_pkg::hex_digit_t    digit;
	logic                    is_x;
	logic                    full;
	logic [63:0]             bias_sum;
	logic [63:0]             acc_div16;
	logic [6:0]              kept_length_d;
	htip_pkg::prefix_mode_t  prefix_mode_d;
	logic [63:0]             acc_value_d;
	logic                    error_seen_d;

	assign term_s1 = htip_pkg::is_terminator(code_s1);

	// The character in the input register is consumed unless it is a terminator and
	// the result register still holds a result that is not being taken.
	assign advance  = valid_s1 && (!term_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	assign digit = htip_pkg::hex_digit(code_s1);
	assign is_x  = (code_s1 == htip_pkg::CH_X_LOWER) || (code_s1 == htip_pkg::CH_X_UPPER);
	assign full  = (kept_length_q >= htip_pkg::MAX_CHARS);

	// Signed divide by 16 truncating toward zero: add 15 to a negative value, then
	// shift arithmetically.
	assign bias_sum  = acc_value_q + {60'd0, {4{acc_value_q[63]}}};
	assign acc_div16 = {{4{bias_sum[63]}}, bias_sum[63:4]};

	always_comb begin
		kept_length_d = kept_length_q;
		prefix_mode_d = prefix_mode_q;
		acc_value_d   = acc_value_q;
		error_seen_d  = error_seen_q;
		if (term_s1) begin
			kept_length_d = 7'd0;
			prefix_mode_d = htip_pkg::PFX_NONE;
			acc_value_d   = 64'd0;
			error_seen_d  = 1'b0;
		end else if (!error_seen_q) begin
			if (code_s1 == htip_pkg::CH_ZERO && kept_length_q == 7'd0) begin
				// A leading zero opens a possible 0x prefix.
				if (full) begin
					error_seen_d = 1'b1;
				end else begin
					kept_length_d = kept_length_q + 7'd1;
					prefix_mode_d = htip_pkg::PFX_ZERO;
				end
			end else if (is_x && kept_length_q == 7'd0) begin
				if (full) begin
					error_seen_d = 1'b1;
				end else begin
					kept_length_d = kept_length_q + 7'd1;
					prefix_mode_d = htip_pkg::PFX_X;
				end
			end else if (is_x && prefix_mode_q == htip_pkg::PFX_ZERO
					&& kept_length_q == 7'd1) begin
				if (full) begin
					error_seen_d = 1'b1;
				end else begin
					kept_length_d = kept_length_q + 7'd1;
					prefix_mode_d = htip_pkg::PFX_0X;
				end
			end else if (digit.ok && prefix_mode_q != htip_pkg::PFX_ZERO) begin
				// Shift in one nibble; the low nibble is zero after the shift, so the add
				// reduces to a concatenation.
				if (full) begin
					error_seen_d = 1'b1;
				end else begin
					kept_length_d = kept_length_q + 7'd1;
					acc_value_d   = {acc_value_q[59:0], digit.value};
				end
			end else if (code_s1 == htip_pkg::CH_BACKSPACE) begin
				if (kept_length_q != 7'd0) begin
					if (kept_length_q == 7'd1 && (prefix_mode_q == htip_pkg::PFX_ZERO
							|| prefix_mode_q == htip_pkg::PFX_X)) begin
						prefix_mode_d = htip_pkg::PFX_NONE;
					end else if (kept_length_q == 7'd2 && prefix_mode_q == htip_pkg::PFX_0X) begin
						prefix_mode_d = htip_pkg::PFX_ZERO;
					end else begin
						acc_value_d = acc_div16;
					end
					kept_length_d = kept_length_q - 7'd1;
				end
			end else begin
				// Anything else spoils the string until the next terminator.
				error_seen_d = 1'b1;
			end
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			kept_length_q <= 7'd0;
			prefix_mode_q <= htip_pkg::PFX_NONE;
			acc_value_q   <= 64'd0;
			error_seen_q  <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				kept_length_q <= kept_length_d;
				prefix_mode_q <= prefix_mode_d;
				acc_value_q   <= acc_value_d;
				error_seen_q  <= error_seen_d;
			end
			if (advance && term_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers, no reset needed.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			code_s1 <= char_code;
		end
		if (advance && term_s1) begin
			parsed_value_q <= acc_value_q;
			char_count_q   <= error_seen_q ? 7'd0 : kept_length_q;
			status_q       <= error_seen_q ? htip_pkg::STATUS_ERR : htip_pkg::STATUS_OK;
		end
	end

	assign out_valid    = out_valid_q;
	assign parsed_value = parsed_value_q;
	assign char_count   = char_count_q;
	assign status       = status_q;

endmodule

`default_nettype wire

>>> src/htip_checker.sv
// Port-level checker for the hex text parser and the bind that attaches it to the
// top level; depends on htip_pkg.
`default_nettype none

module htip_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [63:0] parsed_value,
	input wire logic [6:0]  char_count,
	input wire logic        status
);

	// A result that is not taken holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(parsed_value)
			&& $stable(char_count) && $stable(status))
		else $error("result transaction changed while stalled");

	// A failed string reports a count of zero.
	a_err_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == htip_pkg::STATUS_ERR |-> char_count == 7'd0)
		else $error("error result with nonzero count");

	// The kept count never exceeds the character limit.
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> char_count <= htip_pkg::MAX_CHARS)
		else $error("count beyond character limit");

	// An empty good string always carries a zero value, even after backspaces.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == htip_pkg::STATUS_OK && char_count == 7'd0
			|-> parsed_value == 64'd0)
		else $error("empty string with nonzero value");

	// With the result register empty, the input side never stalls.
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with no pending result");

endmodule

bind hex_text_to_integer_parser_unit htip_checker u_htip_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.parsed_value (parsed_value),
	.char_count   (char_count),
	.status       (status)
);

`default_nettype wire
